// ===== hw/rtl/tkrp_pkg.sv =====
// Shared constants, payload types and cell control for the top-k precision block.
package tkrp_pkg;

    localparam int K_MAX      = 64;
    localparam int SCORE_BITS = 32;
    localparam int LABEL_BITS = 16;
    localparam int K_W        = 7;               // holds 0..K_MAX
    localparam int NUM_W      = 39;              // dividend width, sum <= 2^38
    localparam int CNT_W      = $clog2(NUM_W + 1);
    localparam int OUT_W      = 17;

    localparam logic [K_W-1:0] TOP_K_RESET = K_W'(10);

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] score;
        logic [LABEL_BITS-1:0]        item_label;
        logic [LABEL_BITS-1:0]        query_label;
        logic                         last;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] precision;
        logic [OUT_W-1:0] avg_precision;
        logic [K_W-1:0]   hits;
    } t_out;

    // one slot of the sorted chain; key is offset binary so unsigned order = signed order
    typedef struct packed {
        logic [SCORE_BITS-1:0] key;
        logic [LABEL_BITS-1:0] label;
        logic                  valid;
    } t_entry;

    typedef struct packed {
        logic ins_en;   // insert the broadcast word this cycle
        logic first;    // word opens a set: treat all slots as empty
        logic shift;    // move every slot one place toward the head
    } t_cell_ctl;

endpackage

// ===== hw/rtl/topk_retrieval_precision.sv =====
// Top level: top-k score chain with precision and average precision scoring.
// Non-last words are taken one per cycle; the chain of K_MAX cells inserts each word in place.
// After a last word the block scans k ranks and runs one serial divide per hit
// plus two more before the result word.
// Input is not taken during scoring; a finished result waits in an output register.
// Reset (synchronous, active low) empties the chain, sets top_k to 10 and opens a new set.
module topk_retrieval_precision (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  tkrp_pkg::t_in          i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output tkrp_pkg::t_out         o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [tkrp_pkg::K_W-1:0] i_cfg_data
);
    import tkrp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_DIV_TERM = 6'b000100,
        S_DIV_PREC = 6'b001000,
        S_DIV_AVG  = 6'b010000,
        S_OUT      = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [K_W-1:0]        r_top_k;
    logic [K_W-1:0]        r_k, n_k;
    logic [K_W-1:0]        r_m, n_m;
    logic [K_W-1:0]        r_hits, n_hits;
    logic [NUM_W-1:0]      r_sum, n_sum;
    logic [OUT_W-1:0]      r_prec, n_prec;
    logic [OUT_W-1:0]      r_avg, n_avg;
    logic [LABEL_BITS-1:0] r_held, n_held;
    logic                  r_first, n_first;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    t_cell_ctl             w_ctl;
    t_entry                w_new;
    t_entry                w_ent [K_MAX];
    logic                  w_ins [K_MAX];
    logic                  w_accept;
    logic                  w_div_start;
    logic [NUM_W-1:0]      w_div_num;
    logic [K_W-1:0]        w_div_den;
    logic                  w_div_done;
    logic [NUM_W-1:0]      w_div_quot;
    logic [K_W-1:0]        w_k_sat;
    logic [K_W-1:0]        w_hits_inc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid & o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_new = '{key:   {~i_in_data.score[SCORE_BITS-1], i_in_data.score[SCORE_BITS-2:0]},
                     label: i_in_data.item_label,
                     valid: 1'b1};

    assign w_k_sat    = (r_top_k == '0) ? K_W'(1) :
                        (r_top_k > K_W'(K_MAX)) ? K_W'(K_MAX) : r_top_k;
    assign w_hits_inc = r_hits + K_W'(1);

    genvar gi;
    generate
        for (gi = 0; gi < K_MAX; gi++) begin : g_cell
            t_entry w_prev_e;
            t_entry w_next_e;
            logic   w_prev_i;
            if (gi == 0) begin : g_head
                assign w_prev_e = '0;
                assign w_prev_i = 1'b0;
            end else begin : g_body
                assign w_prev_e = w_ent[gi-1];
                assign w_prev_i = w_ins[gi-1];
            end
            if (gi == K_MAX - 1) begin : g_tail
                assign w_next_e = '0;
            end else begin : g_inner
                assign w_next_e = w_ent[gi+1];
            end
            tkrp_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_new        (w_new),
                .i_prev_entry (w_prev_e),
                .i_prev_ins   (w_prev_i),
                .i_next_entry (w_next_e),
                .o_entry      (w_ent[gi]),
                .o_ins        (w_ins[gi])
            );
        end
    endgenerate

    tkrp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_m         = r_m;
        n_hits      = r_hits;
        n_sum       = r_sum;
        n_prec      = r_prec;
        n_avg       = r_avg;
        n_held      = r_held;
        n_first     = r_first;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_out_ready;
        w_ctl       = '0;
        w_div_start = 1'b0;
        w_div_num   = r_sum;
        w_div_den   = r_k;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctl.ins_en = 1'b1;
                    w_ctl.first  = r_first;
                    if (r_first) begin
                        n_held = i_in_data.query_label;
                    end
                    n_first = i_in_data.last;
                    if (i_in_data.last) begin
                        n_k     = w_k_sat;
                        n_m     = '0;
                        n_hits  = '0;
                        n_sum   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_m == r_k) begin
                    w_div_start = 1'b1;
                    w_div_num   = NUM_W'({r_hits, 16'b0});
                    w_div_den   = r_k;
                    n_state     = S_DIV_PREC;
                end else begin
                    // head slot holds rank r_m+1; pull the next one in behind it
                    w_ctl.shift = 1'b1;
                    n_m         = r_m + K_W'(1);
                    if (w_ent[0].valid && w_ent[0].label == r_held) begin
                        n_hits      = w_hits_inc;
                        w_div_start = 1'b1;
                        w_div_num   = {w_hits_inc, 32'b0};
                        w_div_den   = r_m + K_W'(1);
                        n_state     = S_DIV_TERM;
                    end
                end
            end
            S_DIV_TERM: begin
                if (w_div_done) begin
                    n_sum   = r_sum + w_div_quot;
                    n_state = S_SCAN;
                end
            end
            S_DIV_PREC: begin
                if (w_div_done) begin
                    n_prec      = w_div_quot[OUT_W-1:0];
                    w_div_start = 1'b1;
                    w_div_num   = r_sum;
                    w_div_den   = r_k;
                    n_state     = S_DIV_AVG;
                end
            end
            S_DIV_AVG: begin
                if (w_div_done) begin
                    n_avg   = w_div_quot[OUT_W+15:16];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = '{precision: r_prec, avg_precision: r_avg, hits: r_hits};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top_k     <= TOP_K_RESET;
            r_held      <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_top_k <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_m    <= n_m;
        r_hits <= n_hits;
        r_sum  <= n_sum;
        r_prec <= n_prec;
        r_avg  <= n_avg;
        r_out  <= n_out;
    end

endmodule

// ===== hw/rtl/tkrp_cell.sv =====
// One slot of the descending score chain: compare, insert or pass to a neighbor.
module tkrp_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tkrp_pkg::t_cell_ctl        i_ctl,
    input  tkrp_pkg::t_entry           i_new,
    input  tkrp_pkg::t_entry           i_prev_entry,
    input  logic                       i_prev_ins,
    input  tkrp_pkg::t_entry           i_next_entry,
    output tkrp_pkg::t_entry           o_entry,
    output logic                       o_ins
);
    import tkrp_pkg::*;

    logic [SCORE_BITS-1:0] r_key;
    logic [LABEL_BITS-1:0] r_label;
    logic                  r_valid;
    logic                  w_eff_valid;

    assign w_eff_valid = r_valid & ~i_ctl.first;
    // equal keys stay ahead of the new word
    assign o_ins   = ~w_eff_valid | (i_new.key > r_key);
    assign o_entry = '{key: r_key, label: r_label, valid: w_eff_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_entry.valid;
        end else if (i_ctl.ins_en && o_ins) begin
            r_valid <= i_prev_ins ? i_prev_entry.valid : i_new.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key   <= i_next_entry.key;
            r_label <= i_next_entry.label;
        end else if (i_ctl.ins_en && o_ins) begin
            r_key   <= i_prev_ins ? i_prev_entry.key   : i_new.key;
            r_label <= i_prev_ins ? i_prev_entry.label : i_new.label;
        end
    end

endmodule

// ===== hw/rtl/tkrp_div.sv =====
// Restoring divider, one quotient bit per cycle, small divisor.
module tkrp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tkrp_pkg::NUM_W-1:0]   i_num,
    input  logic [tkrp_pkg::K_W-1:0]     i_den,
    output logic                         o_done,
    output logic [tkrp_pkg::NUM_W-1:0]   o_quot
);
    import tkrp_pkg::*;

    logic [NUM_W-1:0] r_num;
    logic [K_W-1:0]   r_rem;
    logic [K_W-1:0]   r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [K_W:0]     w_trial;
    logic [K_W:0]     w_diff;
    logic             w_qbit;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[K_W-1:0] : w_trial[K_W-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ===== dv/topk_retrieval_precision_tb.sv =====
// Testbench for topk_retrieval_precision: directed table plus random query sets, self-checked.
`timescale 1ns / 100ps

module topk_retrieval_precision_tb;
    import tkrp_pkg::*;

    localparam int  SETTLE_CYCLES = 64;      // quiet time after the last result before a write
    localparam int  HOLD_CYCLES   = 3000;    // long receiver hold-off
    localparam int  PHASE_WORDS   = 210;
    localparam int  NUM_PHASES    = 8;
    localparam longint TIMEOUT_NS = 64'd4_000_000 * 10;

    typedef enum bit {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [K_W-1:0]   k;
        t_in              w;
        bit               typed;
        t_out             want;
    } t_stim_row;

    localparam int NUM_ROWS = 18;
    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        // reset top_k of 10, single hit at the highest score
        '{ROW_WORD, 7'd0, '{32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
          '{17'd6553, 17'd6553, 7'd1}},
        // single miss at the lowest score
        '{ROW_WORD, 7'd0, '{32'h8000_0000, 16'h0000, 16'hFFFF, 1'b1}, 1'b1,
          '{17'd0, 17'd0, 7'd0}},
        // equal scores keep arrival order
        '{ROW_WORD, 7'd0, '{32'd100, 16'd5, 16'd5, 1'b0}, 1'b0, '0},
        '{ROW_WORD, 7'd0, '{32'd100, 16'd7, 16'd1, 1'b0}, 1'b0, '0},
        '{ROW_WORD, 7'd0, '{32'd100, 16'd5, 16'd2, 1'b0}, 1'b0, '0},
        '{ROW_WORD, 7'd0, '{32'hFFFF_FFFF, 16'd5, 16'd3, 1'b1}, 1'b0, '0},
        // top_k of zero acts as one
        '{ROW_CFG, 7'd0, '0, 1'b0, '0},
        '{ROW_WORD, 7'd0, '{32'd0, 16'hAAAA, 16'hAAAA, 1'b1}, 1'b1,
          '{17'd65536, 17'd65536, 7'd1}},
        // top_k above the chain depth saturates
        '{ROW_CFG, 7'd127, '0, 1'b0, '0},
        '{ROW_WORD, 7'd0, '{32'h0001_0000, 16'h5555, 16'h5555, 1'b1}, 1'b1,
          '{17'd1024, 17'd1024, 7'd1}},
        // query among its own candidates, k of one
        '{ROW_CFG, 7'd1, '0, 1'b0, '0},
        '{ROW_WORD, 7'd0, '{32'd5, 16'd3, 16'd9, 1'b0}, 1'b0, '0},
        '{ROW_WORD, 7'd0, '{32'd9, 16'd9, 16'd3, 1'b0}, 1'b0, '0},
        '{ROW_WORD, 7'd0, '{32'hFFFF_FFF9, 16'd9, 16'd0, 1'b1}, 1'b0, '0},
        // k of 64 with only two slots filled
        '{ROW_CFG, 7'd64, '0, 1'b0, '0},
        '{ROW_WORD, 7'd0, '{32'hFFFF_FFFB, 16'd1, 16'd1, 1'b0}, 1'b0, '0},
        '{ROW_WORD, 7'd0, '{32'd3, 16'd1, 16'd0, 1'b1}, 1'b1,
          '{17'd2048, 17'd2048, 7'd2}},
        '{ROW_CFG, 7'd10, '0, 1'b0, '0}
    };

    logic           i_clk;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    t_in            in_data   = '0;
    logic           out_ready = 1'b0;
    logic           cfg_valid = 1'b0;
    logic [K_W-1:0] cfg_data  = '0;
    logic           o_in_ready;
    logic           o_out_valid;
    t_out           o_out_data;
    logic           o_cfg_ready;

    topk_retrieval_precision dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // shadow of the ranking chain
    logic [SCORE_BITS-1:0] chain_key   [K_MAX];
    logic [LABEL_BITS-1:0] chain_label [K_MAX];
    bit                    chain_full  [K_MAX];
    logic [LABEL_BITS-1:0] held_query  = '0;
    bit                    opens_set   = 1'b1;
    logic [K_W-1:0]        k_now       = TOP_K_RESET;

    t_out pending_scores [$];
    int   fail_count = 0;
    bit   idle_en    = 1'b0;
    int   hold_req   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        for (int i = 0; i < K_MAX; i++) chain_full[i] = 1'b0;
    end

    // Inserts one candidate; returns 1 with the scores when the word closes a set.
    function automatic bit rank_candidate(input t_in w, output t_out r);
        int                    pos;
        logic [SCORE_BITS-1:0] key;
        logic [63:0]           kk, nhit, acc;
        r = '0;
        if (opens_set) begin
            for (int i = 0; i < K_MAX; i++) chain_full[i] = 1'b0;
            held_query = w.query_label;
            opens_set  = 1'b0;
        end
        key = w.score ^ 32'h8000_0000;
        pos = 0;
        while (pos < K_MAX && chain_full[pos] && key <= chain_key[pos]) pos++;
        if (pos < K_MAX) begin
            for (int i = K_MAX - 1; i > pos; i--) begin
                chain_key[i]   = chain_key[i-1];
                chain_label[i] = chain_label[i-1];
                chain_full[i]  = chain_full[i-1];
            end
            chain_key[pos]   = key;
            chain_label[pos] = w.item_label;
            chain_full[pos]  = 1'b1;
        end
        if (!w.last) return 1'b0;
        kk = (k_now == 0) ? 64'd1 : (k_now > K_MAX) ? 64'(K_MAX) : 64'(k_now);
        nhit = 0;
        acc  = 0;
        for (int m = 0; m < kk; m++) begin
            if (chain_full[m] && chain_label[m] == held_query) begin
                nhit++;
                acc += (nhit << 32) / 64'(m + 1);
            end
        end
        r.precision     = OUT_W'((nhit << 16) / kk);
        r.avg_precision = OUT_W'((acc / kk) >> 16);
        r.hits          = K_W'(nhit);
        opens_set = 1'b1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    // valid stays up across back-to-back words; here it is lowered only to open a gap (drain_results also lowers it)
    task automatic offer_candidate(input t_in w, input bit typed, input t_out want);
        t_out got;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        if (rank_candidate(w, got))
            pending_scores.push_back(typed ? want : got);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_top_k(input logic [K_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        k_now = v;
    endtask

    task automatic run_query_sets(input int target);
        int                    sent, len, mode, hit_pct;
        logic [LABEL_BITS-1:0] q;
        t_in                   w;
        sent = 0;
        while (sent < target) begin
            // an occasional long set overflows the chain
            len     = ($urandom_range(0, 15) == 0) ? $urandom_range(65, 90)
                                                    : $urandom_range(1, 12);
            mode    = $urandom_range(0, 2);
            hit_pct = $urandom_range(0, 100);
            q       = LABEL_BITS'($urandom);
            for (int i = 0; i < len; i++) begin
                case (mode)
                    0: w.score = $urandom;
                    1: w.score = 32'($urandom_range(0, 16)) - 32'd8;   // many ties
                    default: begin
                        case ($urandom_range(0, 4))
                            0: w.score = 32'h7FFF_FFFF;
                            1: w.score = 32'h8000_0000;
                            2: w.score = 32'h0000_0000;
                            3: w.score = 32'hFFFF_FFFF;
                            default: w.score = $urandom;
                        endcase
                    end
                endcase
                w.item_label  = ($urandom_range(0, 99) < hit_pct) ? q : LABEL_BITS'($urandom);
                w.query_label = (i == 0) ? q : LABEL_BITS'($urandom);
                w.last        = (i == len - 1);
                offer_candidate(w, 1'b0, '0);
            end
            sent += len;
        end
    endtask

    initial begin : rx_side
        int n;
        wait (rst_n);
        forever begin
            if (hold_req > 0) begin
                out_ready <= 1'b0;
                n = hold_req;
                hold_req = 0;
                repeat (n) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_scores.size() == 0) begin
                report_mismatch("result with none pending", 64'd0, 64'(o_out_data));
            end else begin
                want = pending_scores.pop_front();
                if (o_out_data.precision !== want.precision)
                    report_mismatch("precision", 64'(want.precision),
                                    64'(o_out_data.precision));
                if (o_out_data.avg_precision !== want.avg_precision)
                    report_mismatch("avg_precision", 64'(want.avg_precision),
                                    64'(o_out_data.avg_precision));
                if (o_out_data.hits !== want.hits)
                    report_mismatch("hits", 64'(want.hits), 64'(o_out_data.hits));
            end
        end
    end

    initial begin : stim
        logic [K_W-1:0] k_plan [NUM_PHASES];
        k_plan = '{7'd64, 7'd5, 7'd127, 7'd0, 7'd1, K_W'($urandom), 7'd32, 7'd10};
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        idle_en = 1'b1;
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                drain_results();
                write_top_k(DIRECTED[r].k);
            end else begin
                offer_candidate(DIRECTED[r].w, DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_top_k(k_plan[p]);
            idle_en = (p == NUM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
            // receiver stalls long enough for the block to back up into its input
            if (p == 2) hold_req = HOLD_CYCLES;
            run_query_sets(PHASE_WORDS);
        end

        drain_results();
        repeat (200) @(posedge i_clk);
        if (pending_scores.size() != 0)
            report_mismatch("results never delivered", 64'd0, 64'(pending_scores.size()));
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
